@@ src/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types for the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [31:0] q16_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_e;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  typedef struct packed {
    q16_t       t_start;
    q16_t       t_end;
    logic [2:0] dir_zero;
    logic       slab_miss;
  } side_t;

endpackage

@@ src/rbst_if.sv @@
// ----------------------------------------------------------------------------
// rbst_if
// Valid/ready channels for ray beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface rbst_ray_if;
  import rbst_pkg::*;
  logic valid;
  logic ready;
  q16_t origin_x;
  q16_t origin_y;
  q16_t origin_z;
  q16_t dir_x;
  q16_t dir_y;
  q16_t dir_z;
  q16_t t_start;
  q16_t t_end;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_start, t_end, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_start, t_end, output ready);
endinterface

interface rbst_res_if;
  import rbst_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  q16_t t_enter;
  q16_t t_exit;
  modport source (output valid, hit, t_enter, t_exit, input ready);
  modport sink   (input valid, hit, t_enter, t_exit, output ready);
endinterface

interface rbst_cfg_if;
  import rbst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rbst_div.sv @@
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider: ((plane - origin) << 16) / dir, truncated
// toward zero and saturated to 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbst_div
  import rbst_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  q16_t plane_i,
  input  q16_t origin_i,
  input  q16_t dir_i,
  output q16_t quot_o
);

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [31:0]        dmag;

  logic [31:0] r_q   [DIV_STEPS+1];
  logic [32:0] n_q   [DIV_STEPS+1];
  logic [32:0] q_q   [DIV_STEPS+1];
  logic [31:0] d_q   [DIV_STEPS+1];
  logic        s_q   [DIV_STEPS+1];
  logic        ovf_q [DIV_STEPS+1];
  q16_t        quot_q;
  q16_t        quot_d;

  always_comb begin
    diff = {plane_i[31], plane_i} - {origin_i[31], origin_i};
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    dmag = dir_i[31] ? 32'(-dir_i) : 32'(dir_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= {16'd0, mag[32:17]};
      n_q[0]   <= {mag[16:0], 16'd0};
      q_q[0]   <= '0;
      d_q[0]   <= dmag;
      s_q[0]   <= diff[32] ^ dir_i[31];
      ovf_q[0] <= {16'd0, mag[32:17]} >= dmag;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    logic [32:0] rem;

    always_comb begin
      trial = {r_q[k-1], n_q[k-1][32]};
      ge    = trial >= {1'b0, d_q[k-1]};
      rem   = ge ? (trial - {1'b0, d_q[k-1]}) : trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= rem[31:0];
        n_q[k]   <= {n_q[k-1][31:0], 1'b0};
        q_q[k]   <= {q_q[k-1][31:0], ge};
        d_q[k]   <= d_q[k-1];
        s_q[k]   <= s_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  always_comb begin
    if (!s_q[DIV_STEPS]) begin
      if (ovf_q[DIV_STEPS] || q_q[DIV_STEPS][32:31] != 2'b00) quot_d = Q16_MAX;
      else quot_d = q_q[DIV_STEPS][31:0];
    end else begin
      if (ovf_q[DIV_STEPS] || q_q[DIV_STEPS][32] ||
          (q_q[DIV_STEPS][31] && q_q[DIV_STEPS][30:0] != 31'd0)) quot_d = Q16_MIN;
      else quot_d = 32'd0 - q_q[DIV_STEPS][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

@@ src/ray_box_slab_test_core.sv @@
// An accepted ray beat passes the divider pipeline, then the c1, c2 and result registers.
// Throughput: one ray per cycle while the result is not stalled; the divider pipeline sets the depth.
// A stalled result freezes the whole pipeline; no beat is lost or repeated.
// Reset clears valid bits and box registers to zero; no clearing pass.
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray against axis-aligned box, slab clipping in signed Q16.16.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core
  import rbst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rbst_ray_if.sink   ray_i,
  rbst_res_if.source res_o,
  rbst_cfg_if.sink   cfg_i
);

  q16_t box_min_q [NUM_AXES];
  q16_t box_max_q [NUM_AXES];

  logic en;
  q16_t org [NUM_AXES];
  q16_t dir [NUM_AXES];
  q16_t tn_div [NUM_AXES];
  q16_t tf_div [NUM_AXES];
  logic [NUM_AXES-1:0] ax_miss;
  side_t side_in;

  side_t side_q  [DIV_LAT];
  logic  vld_q   [DIV_LAT];

  q16_t  c1_tn_q [NUM_AXES];
  q16_t  c1_tf_q [NUM_AXES];
  side_t c1_side_q;
  logic  c1_vld_q;

  q16_t  c2_t0_q, c2_t1_q;
  logic  c2_miss_q, c2_vld_q;

  logic res_vld_q, res_hit_q;
  q16_t res_enter_q, res_exit_q;

  assign en          = !res_vld_q || res_o.ready;
  assign ray_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_BOX_MIN_X: box_min_q[0] <= cfg_i.data;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_i.data;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_i.data;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_i.data;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_i.data;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    q16_t lo, hi;

    assign lo = (box_min_q[a] < box_max_q[a]) ? box_min_q[a] : box_max_q[a];
    assign hi = (box_min_q[a] < box_max_q[a]) ? box_max_q[a] : box_min_q[a];
    assign ax_miss[a] = (dir[a] == '0) && (org[a] < lo || org[a] > hi);

    rbst_div u_div_min (
      .clk_i    (clk_i),
      .en_i     (en),
      .plane_i  (box_min_q[a]),
      .origin_i (org[a]),
      .dir_i    (dir[a]),
      .quot_o   (tn_div[a])
    );

    rbst_div u_div_max (
      .clk_i    (clk_i),
      .en_i     (en),
      .plane_i  (box_max_q[a]),
      .origin_i (org[a]),
      .dir_i    (dir[a]),
      .quot_o   (tf_div[a])
    );
  end

  always_comb begin
    side_in.t_start   = ray_i.t_start;
    side_in.t_end     = ray_i.t_end;
    side_in.dir_zero  = {dir[2] == '0, dir[1] == '0, dir[0] == '0};
    side_in.slab_miss = |ax_miss;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) vld_q[k] <= 1'b0;
      c1_vld_q  <= 1'b0;
      c2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= ray_i.valid;
      for (int k = 1; k < DIV_LAT; k++) vld_q[k] <= vld_q[k-1];
      c1_vld_q  <= vld_q[DIV_LAT-1];
      c2_vld_q  <= c1_vld_q;
      res_vld_q <= c2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Order each axis pair; a zero direction places no limit.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (side_q[DIV_LAT-1].dir_zero[a]) begin
          c1_tn_q[a] <= Q16_MIN;
          c1_tf_q[a] <= Q16_MAX;
        end else if (tn_div[a] > tf_div[a]) begin
          c1_tn_q[a] <= tf_div[a];
          c1_tf_q[a] <= tn_div[a];
        end else begin
          c1_tn_q[a] <= tn_div[a];
          c1_tf_q[a] <= tf_div[a];
        end
      end
      c1_side_q <= side_q[DIV_LAT-1];
    end
  end

  q16_t mx_a, mx_b, mn_a, mn_b;

  always_comb begin
    mx_a = (c1_tn_q[0] > c1_side_q.t_start) ? c1_tn_q[0] : c1_side_q.t_start;
    mx_b = (c1_tn_q[1] > c1_tn_q[2]) ? c1_tn_q[1] : c1_tn_q[2];
    mn_a = (c1_tf_q[0] < c1_side_q.t_end) ? c1_tf_q[0] : c1_side_q.t_end;
    mn_b = (c1_tf_q[1] < c1_tf_q[2]) ? c1_tf_q[1] : c1_tf_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_t0_q   <= (mx_a > mx_b) ? mx_a : mx_b;
      c2_t1_q   <= (mn_a < mn_b) ? mn_a : mn_b;
      c2_miss_q <= c1_side_q.slab_miss;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (c2_miss_q || c2_t0_q > c2_t1_q) begin
        res_hit_q   <= 1'b0;
        res_enter_q <= '0;
        res_exit_q  <= '0;
      end else begin
        res_hit_q   <= 1'b1;
        res_enter_q <= c2_t0_q;
        res_exit_q  <= c2_t1_q;
      end
    end
  end

  assign res_o.valid   = res_vld_q;
  assign res_o.hit     = res_hit_q;
  assign res_o.t_enter = res_enter_q;
  assign res_o.t_exit  = res_exit_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_hit_q |-> res_enter_q == '0 && res_exit_q == '0)
    else $error("miss beat carries a non-zero interval");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_hit_q |-> res_enter_q <= res_exit_q)
    else $error("hit beat with entry after exit");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c2_vld_q) && $stable(vld_q[DIV_LAT-1]))
    else $error("pipeline moved during stall");
`endif

endmodule
